/* src/fwpid_pkg.sv */
// Shared types, widths and codes for the four wheel position PID block.
// No dependencies; imported by every module of the block.

package fwpid_pkg;

    // Encoder position width and gain fraction bits
    localparam int POSITION_WIDTH = 24;
    localparam int GAIN_FRAC_BITS = 8;

    // Datapath widths
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 28;
    localparam int INT_W     = 48;
    localparam int MAXSPD_W  = 7;
    localparam int SPEED_W   = 16;
    localparam int ERR_CALC_W = ((POSITION_WIDTH > ERR_W) ? POSITION_WIDTH : ERR_W) + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 28;

    // Speed limit ceiling in whole percent, deadband half width in 1/16 degree
    localparam logic [MAXSPD_W-1:0] MAX_SPEED_CAP = 7'd100;
    localparam logic [ERR_W-1:0]    DEADBAND      = 28'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POSITION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_WINDOW = 3'd5;

    // Input word
    typedef struct packed {
        logic                              restart;
        logic signed [POSITION_WIDTH-1:0]  pos_left_front;
        logic signed [POSITION_WIDTH-1:0]  pos_right_back;
        logic signed [POSITION_WIDTH-1:0]  pos_right_front;
        logic signed [POSITION_WIDTH-1:0]  pos_left_back;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [SPEED_W-1:0] drive_speed;
        logic                      settled;
        logic                      limited;
    } t_out_word;

    // Configuration register set
    typedef struct packed {
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic signed [ERR_W-1:0] target_position;
        logic [MAXSPD_W-1:0]     max_speed;
        logic [GAIN_W-1:0]       integral_window;
    } t_cfg;

endpackage

/* src/fwpid_err_stage.sv */
// Error stage: floor average of the four encoder positions, saturated error.
// Depends on fwpid_pkg.

module fwpid_err_stage (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  fwpid_pkg::t_in_word                i_word,
    input  logic signed [fwpid_pkg::ERR_W-1:0] i_target,
    output logic                               o_restart,
    output logic signed [fwpid_pkg::ERR_W-1:0] o_err
);
    import fwpid_pkg::*;

    logic signed [POSITION_WIDTH+1:0] w_sum;
    logic signed [POSITION_WIDTH-1:0] w_avg;
    logic signed [ERR_CALC_W-1:0]     w_diff;
    logic                             w_ovf;
    logic signed [ERR_W-1:0]          n_err;
    logic signed [ERR_W-1:0]          r_err;
    logic                             r_restart;

    // Sum the wheels; dropping two low bits of a signed sum is a floor divide by four
    assign w_sum  = i_word.pos_left_front + i_word.pos_right_back
                  + i_word.pos_right_front + i_word.pos_left_back;
    assign w_avg  = w_sum[POSITION_WIDTH+1:2];
    assign w_diff = i_target - w_avg;

    // Saturate to the error width when the upper bits disagree
    assign w_ovf = (w_diff[ERR_CALC_W-1:ERR_W-1] != {(ERR_CALC_W-ERR_W+1){1'b0}})
                && (w_diff[ERR_CALC_W-1:ERR_W-1] != {(ERR_CALC_W-ERR_W+1){1'b1}});

    always_comb begin
        if (!w_ovf) begin
            n_err = w_diff[ERR_W-1:0];
        end else if (w_diff[ERR_CALC_W-1]) begin
            n_err = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            n_err = {1'b0, {(ERR_W-1){1'b1}}};
        end
    end

    // Hold the error word for the control law stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err     <= n_err;
            r_restart <= i_word.restart;
        end
    end

    assign o_err     = r_err;
    assign o_restart = r_restart;

endmodule

/* src/fwpid_pid_law.sv */
// Control law stage: P, I and D terms, integral and last-error state,
// speed limit, deadband and result register. Depends on fwpid_pkg.

module fwpid_pid_law (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_restart,
    input  logic signed [fwpid_pkg::ERR_W-1:0] i_err,
    input  fwpid_pkg::t_cfg                    i_cfg,
    output fwpid_pkg::t_out_word               o_word
);
    import fwpid_pkg::*;

    localparam int PROD_W  = GAIN_W + 1 + ERR_W;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DPROD_W = GAIN_W + 1 + DIFF_W;
    localparam int RAW_W   = INT_W + 2;
    localparam int SHIFT   = GAIN_FRAC_BITS - 4;
    localparam int LIM_W   = MAXSPD_W + 8;

    logic signed [INT_W-1:0]   r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;
    t_out_word                 r_out_word;

    logic signed [INT_W-1:0]   w_int_base;
    logic signed [ERR_W-1:0]   w_prev_base;
    logic [ERR_W-1:0]          w_mag;
    logic                      w_in_window;
    logic                      w_deadband;
    logic signed [PROD_W-1:0]  w_p_term;
    logic signed [PROD_W-1:0]  w_i_term;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DPROD_W-1:0] w_d_term;
    logic signed [INT_W:0]     w_int_sum;
    logic signed [INT_W-1:0]   n_integral;
    logic signed [RAW_W-1:0]   w_raw;
    logic signed [RAW_W-1:0]   w_speed;
    logic [MAXSPD_W-1:0]       w_cap;
    logic signed [RAW_W-1:0]   w_limit;
    logic signed [SPEED_W-1:0] w_final;
    logic                      w_limited;
    t_out_word                 n_out_word;

    // Restart clears the state ahead of this word
    assign w_int_base  = i_restart ? '0 : r_integral;
    assign w_prev_base = i_restart ? '0 : r_prev_err;

    // Error magnitude, window and deadband tests
    assign w_mag       = i_err[ERR_W-1] ? (~i_err + 1'b1) : i_err;
    assign w_in_window = w_mag < ERR_W'(i_cfg.integral_window);
    assign w_deadband  = w_mag <= DEADBAND;

    // Gain products
    assign w_p_term = $signed({1'b0, i_cfg.gain_p}) * i_err;
    assign w_i_term = $signed({1'b0, i_cfg.gain_i}) * i_err;
    assign w_diff   = {i_err[ERR_W-1], i_err} - {w_prev_base[ERR_W-1], w_prev_base};
    assign w_d_term = $signed({1'b0, i_cfg.gain_d}) * w_diff;

    // Accumulate the integral inside the window, saturating
    assign w_int_sum = w_int_base + w_i_term;
    always_comb begin
        if (!w_in_window) begin
            n_integral = w_int_base;
        end else if (w_int_sum[INT_W] == w_int_sum[INT_W-1]) begin
            n_integral = w_int_sum[INT_W-1:0];
        end else if (w_int_sum[INT_W]) begin
            n_integral = {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            n_integral = {1'b0, {(INT_W-1){1'b1}}};
        end
    end

    // Sum the terms and scale to 1/256 percent, rounding toward minus infinity
    assign w_raw   = w_p_term + n_integral + w_d_term;
    assign w_speed = w_raw >>> SHIFT;

    // Limit and deadband
    assign w_cap   = (i_cfg.max_speed > MAX_SPEED_CAP) ? MAX_SPEED_CAP : i_cfg.max_speed;
    assign w_limit = $signed({{(RAW_W-LIM_W){1'b0}}, w_cap, 8'b0});

    always_comb begin
        if (w_deadband) begin
            w_final   = '0;
            w_limited = 1'b0;
        end else if (w_speed > w_limit) begin
            w_final   = w_limit[SPEED_W-1:0];
            w_limited = 1'b1;
        end else if (w_speed < -w_limit) begin
            w_final   = SPEED_W'(-w_limit);
            w_limited = 1'b1;
        end else begin
            w_final   = w_speed[SPEED_W-1:0];
            w_limited = 1'b0;
        end
    end

    always_comb begin
        n_out_word.drive_speed = w_final;
        n_out_word.settled     = (w_final > -SPEED_W'(256)) && (w_final < SPEED_W'(256));
        n_out_word.limited     = w_limited;
    end

    // Advance the controller state with each word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_en) begin
            r_integral <= n_integral;
            r_prev_err <= i_err;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_word = r_out_word;

endmodule

/* src/four_wheel_position_pid_top.sv */
// Four wheel position PID: an accepted input word moves through the input, error
// and output registers to its result word; throughput one word per cycle while the
// output is not stalled, set by the integral update in the control law stage.
// Reset (synchronous, active low) restores the register defaults, clears the
// integral and last error and empties the pipeline. No clearing pass.
// Depends on fwpid_pkg, fwpid_err_stage and fwpid_pid_law.

module four_wheel_position_pid_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  fwpid_pkg::t_in_word                   i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output fwpid_pkg::t_out_word                  o_out_word,
    input  logic                                  i_cfg_wr_en,
    input  logic [fwpid_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fwpid_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fwpid_pkg::*;

    t_cfg      r_cfg;
    t_in_word  r_in_word;
    logic      r_in_valid;
    logic      r_err_valid;
    logic      r_out_valid;

    logic      w_out_ready;
    logic      w_err_ready;
    logic      w_in_ready;
    logic      w_err_restart;
    logic signed [ERR_W-1:0] w_err;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= 16'd95;
            r_cfg.gain_i          <= 16'd0;
            r_cfg.gain_d          <= 16'd77;
            r_cfg.target_position <= '0;
            r_cfg.max_speed       <= 7'd100;
            r_cfg.integral_window <= 16'd800;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_TARGET_POSITION: begin
                    r_cfg.target_position <= i_cfg_data[ERR_W-1:0];
                end
                CFG_MAX_SPEED: begin
                    r_cfg.max_speed <= i_cfg_data[MAXSPD_W-1:0];
                end
                CFG_INTEGRAL_WINDOW: begin
                    r_cfg.integral_window <= i_cfg_data[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage enables: a stage moves on when it is empty or its successor moves
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_err_ready = !r_err_valid || w_out_ready;
    assign w_in_ready  = !r_in_valid || w_err_ready;
    assign o_in_stall  = !w_in_ready;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_err_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_err_ready) begin
                r_err_valid <= r_in_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_err_valid;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    fwpid_err_stage u_err_stage (
        .i_clk     (i_clk),
        .i_en      (w_err_ready && r_in_valid),
        .i_word    (r_in_word),
        .i_target  (r_cfg.target_position),
        .o_restart (w_err_restart),
        .o_err     (w_err)
    );

    fwpid_pid_law u_pid_law (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_out_ready && r_err_valid),
        .i_restart (w_err_restart),
        .i_err     (w_err),
        .i_cfg     (r_cfg),
        .o_word    (o_out_word)
    );

    assign o_out_valid = r_out_valid;

endmodule

/* src/fwpid_checker.sv */
// Port-level checks on the result channel of the four wheel position PID.
// Depends on fwpid_pkg; bound to four_wheel_position_pid_top below.

module fwpid_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  fwpid_pkg::t_out_word o_out_word
);
    import fwpid_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Settled flag agrees with the speed magnitude
    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.settled ==
            ((o_out_word.drive_speed > -SPEED_W'(256))
            && (o_out_word.drive_speed < SPEED_W'(256)))))
        else $error("settled flag disagrees with speed");

    // A limited speed is a whole percent and the speed never exceeds 100 percent
    a_limited_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.limited) |-> (o_out_word.drive_speed[7:0] == 8'd0))
        else $error("limited speed not a whole percent");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.drive_speed <= SPEED_W'(25600))
            && (o_out_word.drive_speed >= -SPEED_W'(25600))))
        else $error("speed beyond full scale");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

endmodule

bind four_wheel_position_pid_top fwpid_checker u_fwpid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
